### rtl/core/pot_pkg.sv
// Shared types, constants and helpers for the perceptron online trainer.
package pot_pkg;

    // Item kinds
    localparam logic KIND_TRAIN    = 1'b0;
    localparam logic KIND_CLASSIFY = 1'b1;

    localparam int unsigned FEAT_W  = 8;
    localparam int unsigned WEIGHT_W = 24;
    localparam int unsigned RATE_W  = 8;
    localparam int unsigned TALLY_W = 16;
    localparam int unsigned PROD_W  = FEAT_W + WEIGHT_W;
    localparam int unsigned STEP_W  = RATE_W + FEAT_W + 1;
    localparam int unsigned WIDE_W  = WEIGHT_W + 2;

    localparam logic [RATE_W-1:0]  RATE_RESET = 8'd26;
    localparam logic [TALLY_W-1:0] TALLY_MAX  = 16'hFFFF;
    localparam logic signed [WEIGHT_W-1:0] W_MAX = 24'sh7FFFFF;
    localparam logic signed [WEIGHT_W-1:0] W_MIN = 24'sh800000;

    typedef logic signed [FEAT_W-1:0]   feature_t;
    typedef logic signed [WEIGHT_W-1:0] weight_t;
    typedef logic signed [PROD_W-1:0]   product_t;
    typedef logic [RATE_W-1:0]          rate_t;
    typedef logic [TALLY_W-1:0]         tally_t;

    // Update command from the merge stage to every lane
    typedef struct packed {
        logic update;
        logic negative;
    } lane_ctrl_t;

    // One result beat
    typedef struct packed {
        logic   prediction;
        logic   mismatch;
        tally_t epoch_errors;
        logic   converged;
    } result_t;

    // Clamp a widened sum back into the signed weight range
    function automatic weight_t sat_weight(input logic signed [WIDE_W-1:0] value);
        weight_t clamped;
        if (value[WIDE_W-1:WEIGHT_W-1] == '0 || value[WIDE_W-1:WEIGHT_W-1] == '1)
        begin
            clamped = value[WEIGHT_W-1:0];
        end
        else if (value[WIDE_W-1])
        begin
            clamped = W_MIN;
        end
        else
        begin
            clamped = W_MAX;
        end
        return clamped;
    endfunction

endpackage

### rtl/core/pot_chan_if.sv
// Sample and result channel interfaces with valid/ready handshake.
interface pot_sample_if #(parameter int LANES = 2) ();
    logic                 valid;
    logic                 ready;
    logic                 kind;
    logic [8*LANES-1:0]   features;
    logic                 target;
    logic                 epoch_last;

    modport source (output valid, kind, features, target, epoch_last, input ready);
    modport sink   (input valid, kind, features, target, epoch_last, output ready);
endinterface

interface pot_result_if ();
    logic        valid;
    logic        ready;
    logic        prediction;
    logic        mismatch;
    logic [15:0] epoch_errors;
    logic        converged;

    modport source (output valid, prediction, mismatch, epoch_errors, converged,
                    input ready);
    modport sink   (input valid, prediction, mismatch, epoch_errors, converged,
                    output ready);
endinterface

### rtl/core/perceptron_online_trainer_top.sv
// Top level of the perceptron online trainer: lanes, merge and output buffer.
//
//   channel    dir  handshake        beat contents
//   samples    in   valid/ready      kind, features (LANES x int8), target, epoch_last
//   results    out  valid/ready      prediction, mismatch, epoch_errors, converged
//   cfg        in   cfg_we           cfg_data = learning_rate (Q0.8)
//
// One sample per cycle while samples.ready is high: the lane multipliers, the lane
// sum and the weight update all settle in the cycle of acceptance, so the next sample
// sees new weights. Each result is registered in a two-entry output buffer (main
// and skid register) that keeps samples flowing while results stall; samples stop
// only once both entries are full. Reset clears weights, bias, tally and
// buffer, and loads learning_rate with 26.
module perceptron_online_trainer_top #(
    parameter int LANES = 2
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    pot_sample_if.sink           samples,
    pot_result_if.source         results,
    input  logic                 cfg_we,
    input  logic [7:0]           cfg_data
);

    pot_pkg::rate_t      rate_reg;
    pot_pkg::lane_ctrl_t ctrl;
    pot_pkg::result_t    result;
    pot_pkg::product_t   products [LANES];
    pot_pkg::result_t    main_reg;
    pot_pkg::result_t    skid_reg;
    logic                main_valid_reg;
    logic                skid_valid_reg;
    logic                fire;

    assign fire = samples.valid && samples.ready;

    // Hold the learning rate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= pot_pkg::RATE_RESET;
        end
        else if (cfg_we)
        begin
            rate_reg <= cfg_data;
        end
    end

    // Lanes
    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        pot_lane u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .feature (pot_pkg::feature_t'(samples.features[8*i +: 8])),
            .rate    (rate_reg),
            .ctrl    (ctrl),
            .product (products[i])
        );
    end

    pot_merge #(.LANES(LANES)) u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .kind       (samples.kind),
        .target     (samples.target),
        .epoch_last (samples.epoch_last),
        .rate       (rate_reg),
        .products   (products),
        .ctrl       (ctrl),
        .result     (result)
    );

    // Output buffer control: refill main from skid first, else from the new beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!main_valid_reg || results.ready)
        begin
            if (skid_valid_reg)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= fire;
            end
        end
        else if (fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Output buffer payload
    always_ff @(posedge clk)
    begin
        if (!main_valid_reg || results.ready)
        begin
            main_reg <= skid_valid_reg ? skid_reg : result;
        end
        else if (fire)
        begin
            skid_reg <= result;
        end
    end

    assign samples.ready        = !skid_valid_reg;
    assign results.valid        = main_valid_reg;
    assign results.prediction   = main_reg.prediction;
    assign results.mismatch     = main_reg.mismatch;
    assign results.epoch_errors = main_reg.epoch_errors;
    assign results.converged    = main_reg.converged;

endmodule

### rtl/core/pot_lane.sv
// One lane: holds a weight, forms feature*weight and applies the update.
module pot_lane
(
    input  logic                clk,
    input  logic                rst_n,
    input  pot_pkg::feature_t   feature,
    input  pot_pkg::rate_t      rate,
    input  pot_pkg::lane_ctrl_t ctrl,
    output pot_pkg::product_t   product
);

    pot_pkg::weight_t weight_reg;
    pot_pkg::weight_t weight_next;
    logic signed [pot_pkg::RATE_W:0]         rate_s;
    logic signed [pot_pkg::STEP_W-1:0]       step;
    logic signed [pot_pkg::WIDE_W-1:0]       weight_wide;
    logic signed [pot_pkg::WIDE_W-1:0]       step_wide;
    logic signed [pot_pkg::WIDE_W-1:0]       sum_wide;

    // Form the dot product term
    assign product = pot_pkg::product_t'(feature) * pot_pkg::product_t'(weight_reg);

    // Form rate times feature, then add or subtract and clamp
    assign rate_s      = {1'b0, rate};
    assign step        = pot_pkg::STEP_W'(rate_s) * pot_pkg::STEP_W'(feature);
    assign weight_wide = pot_pkg::WIDE_W'(weight_reg);
    assign step_wide   = pot_pkg::WIDE_W'(step);
    assign sum_wide    = ctrl.negative ? (weight_wide - step_wide)
                                       : (weight_wide + step_wide);
    assign weight_next = pot_pkg::sat_weight(sum_wide);

    // Hold the weight until a mistaken training beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= '0;
        end
        else if (ctrl.update)
        begin
            weight_reg <= weight_next;
        end
    end

endmodule

### rtl/core/pot_merge.sv
// Merge stage: adds lane products and bias, decides, updates bias and tally.
module pot_merge #(
    parameter int LANES = 2
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic                kind,
    input  logic                target,
    input  logic                epoch_last,
    input  pot_pkg::rate_t      rate,
    input  pot_pkg::product_t   products [LANES],
    output pot_pkg::lane_ctrl_t ctrl,
    output pot_pkg::result_t    result
);

    localparam int SUM_W = pot_pkg::PROD_W + $clog2(LANES + 1);

    pot_pkg::weight_t bias_reg;
    pot_pkg::weight_t bias_next;
    pot_pkg::tally_t  tally_reg;
    pot_pkg::tally_t  tally_next;
    pot_pkg::tally_t  count;
    logic signed [SUM_W-1:0]           sum;
    logic signed [pot_pkg::WIDE_W-1:0] bias_wide;
    logic signed [pot_pkg::WIDE_W-1:0] rate_wide;
    logic                              prediction;
    logic                              miss;

    // Sum lane products and bias
    always_comb
    begin
        sum = SUM_W'(bias_reg);
        for (int i = 0; i < LANES; i++)
        begin
            sum = sum + SUM_W'(products[i]);
        end
    end

    // Decide and flag a training mistake
    assign prediction = (sum > SUM_W'(0));
    assign miss       = (kind == pot_pkg::KIND_TRAIN) && (prediction != target);

    assign ctrl.update   = fire && miss;
    assign ctrl.negative = !target;

    // Step the bias up or down by the rate, as the target says, and clamp
    assign bias_wide = pot_pkg::WIDE_W'(bias_reg);
    assign rate_wide = pot_pkg::WIDE_W'({1'b0, rate});
    assign bias_next = pot_pkg::sat_weight(target ? (bias_wide + rate_wide)
                                                  : (bias_wide - rate_wide));

    // Count mistakes with saturation; clear after the epoch end
    assign count      = (miss && tally_reg != pot_pkg::TALLY_MAX) ? tally_reg + 1'b1
                                                                  : tally_reg;
    assign tally_next = epoch_last ? '0 : count;

    assign result.prediction   = prediction;
    assign result.mismatch     = miss;
    assign result.epoch_errors = count;
    assign result.converged    = epoch_last && (count == '0);

    // Advance bias and tally on an accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_reg  <= '0;
            tally_reg <= '0;
        end
        else if (fire)
        begin
            tally_reg <= tally_next;
            if (miss)
            begin
                bias_reg <= bias_next;
            end
        end
    end

endmodule
